### rtl/tcw_pkg.sv
// Shared types, constants and tables for the text console writer.
package tcw_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  // widest linear index: row 31, column 255 (put) or 127 (read)
  localparam int LIN_W  = $clog2(31 * COLS + 255 + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NULL    = 8'd0;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_NEWLINE,
    OP_TAB,
    OP_PUT,
    OP_SET,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_SCROLL,
    BK_ZERO,
    BK_EXEC,
    BK_CLEAR,
    BK_RESP
  } bk_state_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  char_code;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [3:0]  fill_color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [7:0]  cursor_col;
    logic [4:0]  cursor_row;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        char_code;
    logic [6:0]        col;
    logic [4:0]        row;
    logic [3:0]        fill_color;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [3:0] fg_color;
    logic [3:0] bg_color;
  } color_cfg_t;

  // next tab stop for every column value, saturating at 255
  typedef logic [255:0][7:0] tab_tbl_t;

  function automatic tab_tbl_t build_tab_tbl();
    tab_tbl_t t;
    int       s;
    for (int i = 0; i < 256; i++) begin
      s = i + TAB_STOP - (i % TAB_STOP);
      t[i] = (s > 255) ? 8'd255 : 8'(s);
    end
    return t;
  endfunction

  localparam tab_tbl_t TAB_TBL = build_tab_tbl();

endpackage

### rtl/tcw_front.sv
// Front end: takes commands, classifies them and computes read addresses.
module tcw_front import tcw_pkg::*; (
  input  logic     start,
  input  in_item_t in_data,
  input  logic     q_full,
  input  logic     init_busy,
  output logic     busy,
  output logic     push,
  output cmd_t     push_cmd
);

  logic [LIN_W-1:0] rd_lin;
  op_t              op;

  assign busy = q_full | init_busy;
  assign push = start & ~busy;

  assign rd_lin = LIN_W'(in_data.row) * LIN_W'(COLS) + LIN_W'(in_data.col);

  always_comb begin
    case (in_data.action)
      ACT_PUT: begin
        if (in_data.char_code == CH_NULL) begin
          op = OP_NOP;
        end else if (in_data.char_code == CH_NEWLINE) begin
          op = OP_NEWLINE;
        end else if (in_data.char_code == CH_TAB) begin
          op = OP_TAB;
        end else begin
          op = OP_PUT;
        end
      end
      ACT_SET:   op = OP_SET;
      ACT_CLEAR: op = OP_CLEAR;
      ACT_READ:  op = OP_READ;
      default:   op = OP_NOP;
    endcase
  end

  always_comb begin
    push_cmd.op         = op;
    push_cmd.char_code  = in_data.char_code;
    push_cmd.col        = in_data.col;
    push_cmd.row        = in_data.row;
    push_cmd.fill_color = in_data.fill_color;
    push_cmd.rd_addr    = rd_lin[ADDR_W-1:0];
    push_cmd.rd_ok      = (rd_lin < LIN_W'(CELLS));
  end

endmodule

### rtl/tcw_queue.sv
// Short command queue between front and back end.
module tcw_queue import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign head         = slots_r[rptr_r];
  assign status.full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/tcw_back.sv
// Back end: cursor, cell store and the sequencer for put, scroll, clear and read.
module tcw_back import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  color_cfg_t colors,
  input  cmd_t       head,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       init_busy,
  output logic       out_strobe,
  output out_item_t  out_data
);

  bk_state_t state_r, state_nxt;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // write stage: issued one cycle, lands in the memory the next
  logic              wr_en_r, wr_en_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [15:0]       wr_data_r, wr_data_nxt;
  logic              wr_copy_r, wr_copy_nxt;

  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [7:0]        cur_col_r, cur_col_nxt;
  logic [4:0]        cur_row_r, cur_row_nxt;

  logic [LIN_W-1:0]  put_lin;
  logic              need_scroll;
  logic              ptr_last;
  logic              text_op;

  assign put_lin     = LIN_W'(cur_row_r) * LIN_W'(COLS) + LIN_W'(cur_col_r);
  assign need_scroll = (cur_row_r >= 5'(ROWS));
  assign ptr_last    = (ptr_r == ADDR_W'(CELLS - 1));
  assign text_op     = (head.op == OP_NEWLINE) || (head.op == OP_TAB) || (head.op == OP_PUT);

  // hold off a new command while a write is still landing
  assign pop = (state_r == BK_IDLE) && !q_status.empty && !wr_en_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_INIT: begin
        if (ptr_last) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (pop) begin
          if (head.op == OP_CLEAR) begin
            state_nxt = BK_CLEAR;
          end else if (text_op) begin
            state_nxt = need_scroll ? BK_SCROLL : BK_EXEC;
          end else begin
            state_nxt = BK_RESP;
          end
        end
      end
      BK_SCROLL: begin
        if (ptr_r == ADDR_W'(CELLS - COLS - 1)) state_nxt = BK_ZERO;
      end
      BK_ZERO: begin
        if (ptr_last) state_nxt = BK_EXEC;
      end
      BK_EXEC:  state_nxt = BK_RESP;
      BK_CLEAR: begin
        if (ptr_last) state_nxt = BK_RESP;
      end
      BK_RESP:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ptr_nxt     = ptr_r;
    cmd_nxt     = cmd_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    wr_en_nxt   = 1'b0;
    wr_addr_nxt = ptr_r;
    wr_data_nxt = 16'd0;
    wr_copy_nxt = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head.rd_addr;
    case (state_r)
      BK_INIT: begin
        wr_en_nxt = 1'b1;
        ptr_nxt   = ptr_r + 1'b1;
      end
      BK_IDLE: begin
        if (pop) begin
          cmd_nxt = head;
          ptr_nxt = '0;
          if (head.op == OP_SET) begin
            cur_col_nxt = {1'b0, head.col};
            cur_row_nxt = head.row;
          end
          if (head.op == OP_READ) begin
            rd_en = 1'b1;
          end
        end
      end
      BK_SCROLL: begin
        rd_en       = 1'b1;
        rd_addr     = ptr_r + ADDR_W'(COLS);
        wr_en_nxt   = 1'b1;
        wr_copy_nxt = 1'b1;
        ptr_nxt     = ptr_r + 1'b1;
      end
      BK_ZERO: begin
        wr_en_nxt = 1'b1;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_last) cur_row_nxt = cur_row_r - 5'd1;
      end
      BK_EXEC: begin
        case (cmd_r.op)
          OP_NEWLINE: begin
            cur_col_nxt = 8'd0;
            cur_row_nxt = cur_row_r + 5'd1;
          end
          OP_TAB: cur_col_nxt = TAB_TBL[cur_col_r];
          OP_PUT: begin
            wr_en_nxt   = (put_lin < LIN_W'(CELLS));
            wr_addr_nxt = put_lin[ADDR_W-1:0];
            wr_data_nxt = {colors.bg_color, colors.fg_color, cmd_r.char_code};
            cur_col_nxt = (cur_col_r == 8'd255) ? 8'd255 : cur_col_r + 8'd1;
          end
          default: ;
        endcase
      end
      BK_CLEAR: begin
        wr_en_nxt   = 1'b1;
        wr_data_nxt = {cmd_r.fill_color, colors.fg_color, CH_SPACE};
        ptr_nxt     = ptr_r + 1'b1;
      end
      BK_RESP: ;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    init_busy           = (state_r == BK_INIT);
    out_strobe          = (state_r == BK_RESP);
    out_data.cell_word  = (cmd_r.op == OP_READ && cmd_r.rd_ok) ? rdata_r : 16'd0;
    out_data.cursor_col = cur_col_r;
    out_data.cursor_row = cur_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_INIT;
      ptr_r     <= '0;
      wr_en_r   <= 1'b0;
      cur_col_r <= 8'd0;
      cur_row_r <= 5'd0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      wr_en_r   <= wr_en_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    wr_addr_r <= wr_addr_nxt;
    wr_data_r <= wr_data_nxt;
    wr_copy_r <= wr_copy_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem[wr_addr_r] <= wr_copy_r ? rdata_r : wr_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_clear_keeps_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |=> ($stable(cur_col_r) && $stable(cur_row_r)))
    else $error("cursor moved during clear sweep");

  a_scroll_dec_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EXEC && $past(state_r) == BK_ZERO) |->
      (cur_row_r == $past(cur_row_r) - 5'd1))
    else $error("scroll did not step the cursor row back");

  a_copy_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en_r && wr_copy_r) |-> (state_r == BK_SCROLL || state_r == BK_ZERO))
    else $error("cell copy outside a scroll");

endmodule

### rtl/text_console_writer.sv
// Text console writer: a COLS x ROWS store of 16-bit cells with a cursor.
// A command is taken when start is high and busy is low; each command yields
// exactly one result beat on out_data, marked by out_strobe for one cycle,
// which the receiver must take as it comes. A put, newline or tab passes
// through the EXEC state before the strobe; set cursor, read and ignored
// bytes go from the queue straight to the strobe. A put, newline or tab
// with the cursor row past the last row first scrolls, one cell per cycle
// through the store, then blanks the last row. Clear screen writes one cell
// per cycle. After reset the block holds busy high while it zeroes the
// store; configuration writes are taken during that time. A two-entry queue
// lets up to two commands be taken while an earlier one is still at work.
module text_console_writer import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_strobe,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]           cfg_data
);

  logic [3:0] text_col_r, text_col_nxt;
  logic [3:0] back_col_r, back_col_nxt;
  color_cfg_t colors;

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       head;
  q_status_t  q_status;
  logic       init_busy;

  always_comb begin
    text_col_nxt = text_col_r;
    back_col_nxt = back_col_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FG_COLOR: text_col_nxt = cfg_data;
        REG_BG_COLOR: back_col_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_col_r <= 4'd15;
      back_col_r <= 4'd0;
    end else begin
      text_col_r <= text_col_nxt;
      back_col_r <= back_col_nxt;
    end
  end

  assign colors.fg_color = text_col_r;
  assign colors.bg_color = back_col_r;

  tcw_front u_front (
    .start     (start),
    .in_data   (in_data),
    .q_full    (q_status.full),
    .init_busy (init_busy),
    .busy      (busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .colors     (colors),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .init_busy  (init_busy),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_no_push_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !push)
    else $error("command taken while the store is being zeroed");

  a_cfg_reset_val: assert property (@(posedge clk)
    !rst_n |=> (text_col_r == 4'd15 && back_col_r == 4'd0))
    else $error("colour registers not at reset value");

  a_strobe_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !init_busy)
    else $error("result beat during store zeroing");

endmodule
